[design/lpeq_pkg.sv]
// Shared types, codes and the discard rule for the lossy priority event queue.
package lpeq_pkg;

  // Operation codes
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  // Event kinds
  localparam logic [2:0] KIND_KEY    = 3'd0;
  localparam logic [2:0] KIND_BUTTON = 3'd1;
  localparam logic [2:0] KIND_CURSOR = 3'd2;
  localparam logic [2:0] KIND_SIZE   = 3'd3;
  localparam logic [2:0] KIND_FOCUS  = 3'd4;
  localparam logic [2:0] KIND_CLOSE  = 3'd5;
  localparam logic [2:0] KIND_CHAR   = 3'd6;
  localparam logic [2:0] KIND_SCROLL = 3'd7;

  // Event actions
  localparam logic [1:0] ACT_RELEASE = 2'd0;
  localparam logic [1:0] ACT_PRESS   = 2'd1;
  localparam logic [1:0] ACT_REPEAT  = 2'd2;

  // One queued event
  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] code;
    logic [1:0]  action;
    logic [63:0] x;
    logic [63:0] y;
  } entry_t;

  // Per-cell control from the sequencer
  typedef struct packed {
    logic load;   // take the incoming word
    logic shift;  // take the younger neighbor's word
  } cell_ctrl_t;

  // Releases of keys and buttons, focus and close must be kept; all else may go
  function automatic logic may_drop(input logic [2:0] kind, input logic [1:0] action);
    logic res;
    res = 1'b1;
    case (kind) inside
      KIND_KEY, KIND_BUTTON: res = (action != ACT_RELEASE);
      KIND_FOCUS, KIND_CLOSE: res = 1'b0;
      default: res = 1'b1;
    endcase
    return res;
  endfunction

endpackage

[design/lpeq_cell.sv]
// One queue cell: holds an entry and ripples the older-discardable mark.
module lpeq_cell import lpeq_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cell_ctrl_t ctrl,
  input  entry_t     load_entry,
  input  entry_t     next_entry,
  input  logic       prev_mark,
  input  logic       prev_disc,
  output entry_t     entry,
  output logic       disc,
  output logic       mark
);

  // Flag own content as discardable
  assign disc = may_drop(entry.kind, entry.action);

  // Hold, load a new word, or advance toward the head
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      entry <= load_entry;
    end else if (ctrl.shift) begin
      entry <= next_entry;
    end
  end

  // Advance the mark one cell per cycle: some older cell is discardable
  always_ff @(posedge clk) begin
    if (rst) begin
      mark <= 1'b0;
    end else begin
      mark <= prev_mark | prev_disc;
    end
  end

endmodule

[design/lossy_priority_event_queue.sv]
// Pop, non-full push: result word the next cycle; one item per cycle unless out_ready stalls.
// Push into a full queue: the word is held while the discard mark ripples one cell per cycle
//   down the cell chain; then, with the output free, the eviction shift or a refusal.
// A new word is taken only when the output register is empty or being drained.
// Reset empties the queue and clears the drop counter; cell contents are left as they are.
module lossy_priority_event_queue import lpeq_pkg::*; #(
  parameter int QUEUE_DEPTH = 64
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             opcode,
  input  logic [2:0]                       event_kind,
  input  logic signed [15:0]               event_code,
  input  logic [1:0]                       event_action,
  input  logic [63:0]                      payload_x,
  input  logic [63:0]                      payload_y,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             accepted,
  output logic                             pop_valid,
  output logic [2:0]                       out_kind,
  output logic signed [15:0]               out_code,
  output logic [1:0]                       out_action,
  output logic [63:0]                      out_x,
  output logic [63:0]                      out_y,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0] pending,
  output logic [31:0]                      drop_total
);

  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
  localparam int IDX_W  = $clog2(QUEUE_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SCAN  = 3'b010,
    S_APPLY = 3'b100
  } state_t;

  state_t            state, state_next;
  logic [IDX_W-1:0]  scan_cnt;
  logic [FILL_W-1:0] fill, fill_next;
  logic [31:0]       drop_cnt, drop_next;
  entry_t            hold_entry;
  entry_t            in_entry;
  entry_t            load_entry;

  entry_t                 cell_entry [QUEUE_DEPTH];
  cell_ctrl_t             cell_ctrl  [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] cell_disc;
  logic [QUEUE_DEPTH-1:0] cell_mark;

  logic accept, out_free, full, found;
  logic do_pop, do_push, do_full, do_apply;

  // Handshake and step decode
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE) && out_free;
  assign accept   = in_valid && in_ready;
  assign full     = (fill == FILL_W'(QUEUE_DEPTH));
  assign found    = cell_mark[QUEUE_DEPTH-1] | cell_disc[QUEUE_DEPTH-1];
  assign do_pop   = accept && (opcode == OP_POP) && (fill != '0);
  assign do_push  = accept && (opcode == OP_PUSH) && !full;
  assign do_full  = accept && (opcode == OP_PUSH) && full;
  assign do_apply = (state == S_APPLY) && out_free;

  assign in_entry.kind   = event_kind;
  assign in_entry.code   = event_code;
  assign in_entry.action = event_action;
  assign in_entry.x      = payload_x;
  assign in_entry.y      = payload_y;
  assign load_entry      = (state == S_APPLY) ? hold_entry : in_entry;

  // Build the cell chain; the head is cell 0
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign cell_ctrl[i].load  = (do_push && (fill == FILL_W'(i))) || (do_apply && found);
      assign cell_ctrl[i].shift = 1'b0;
    end else begin : g_body
      assign cell_ctrl[i].load  = do_push && (fill == FILL_W'(i));
      assign cell_ctrl[i].shift = do_pop ||
                                  (do_apply && found && (cell_mark[i] || cell_disc[i]));
    end

    lpeq_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (cell_ctrl[i]),
      .load_entry (load_entry),
      .next_entry ((i == QUEUE_DEPTH - 1) ? cell_entry[i] :
                   cell_entry[(i + 1) % QUEUE_DEPTH]),
      .prev_mark  ((i == 0) ? 1'b0 : cell_mark[(i + QUEUE_DEPTH - 1) % QUEUE_DEPTH]),
      .prev_disc  ((i == 0) ? 1'b0 : cell_disc[(i + QUEUE_DEPTH - 1) % QUEUE_DEPTH]),
      .entry      (cell_entry[i]),
      .disc       (cell_disc[i]),
      .mark       (cell_mark[i])
    );
  end

  // Sequencer: idle, wait for the mark ripple, then evict or refuse
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (do_full) state_next = S_SCAN;
      end
      S_SCAN: begin
        if (scan_cnt == IDX_W'(QUEUE_DEPTH - 2)) state_next = S_APPLY;
      end
      S_APPLY: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Fill level and saturating drop count after this step
  always_comb begin
    fill_next = fill;
    drop_next = drop_cnt;
    if (do_pop) fill_next = fill - FILL_W'(1);
    if (do_push) fill_next = fill + FILL_W'(1);
    if (do_apply && (drop_cnt != '1)) drop_next = drop_cnt + 32'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      scan_cnt <= '0;
      fill     <= '0;
      drop_cnt <= '0;
    end else begin
      state    <= state_next;
      fill     <= fill_next;
      drop_cnt <= drop_next;
      if (do_full) begin
        scan_cnt <= '0;
      end else if (state == S_SCAN) begin
        scan_cnt <= scan_cnt + IDX_W'(1);
      end
    end
  end

  // Hold the incoming word while the eviction search runs
  always_ff @(posedge clk) begin
    if (do_full) hold_entry <= in_entry;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && !do_full) begin
      out_valid <= 1'b1;
    end else if (do_apply) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((accept && !do_full) || do_apply) begin
      accepted   <= do_push || (do_apply && found);
      pop_valid  <= do_pop;
      pending    <= fill_next;
      drop_total <= drop_next;
      if (do_pop) begin
        out_kind   <= cell_entry[0].kind;
        out_code   <= cell_entry[0].code;
        out_action <= cell_entry[0].action;
        out_x      <= cell_entry[0].x;
        out_y      <= cell_entry[0].y;
      end else begin
        out_kind   <= '0;
        out_code   <= '0;
        out_action <= '0;
        out_x      <= '0;
        out_y      <= '0;
      end
    end
  end

  // Fill level never passes the depth
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_W'(QUEUE_DEPTH))
    else $error("fill level beyond depth");

  // The eviction search only runs on a full queue
  a_scan_full: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN || state == S_APPLY) |-> full)
    else $error("eviction search on a non-full queue");

  // A result word never reports both a stored push and a pop
  a_one_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(accepted && pop_valid))
    else $error("result marks both push and pop");

  // Finishing an eviction search always counts one drop unless saturated
  a_drop_count: assert property (@(posedge clk) disable iff (rst)
    do_apply |=> (drop_cnt == $past(drop_cnt) + 32'd1) || ($past(drop_cnt) == '1))
    else $error("drop not counted");

  // Pending never changes across a full-queue push
  a_full_hold: assert property (@(posedge clk) disable iff (rst)
    do_apply |=> fill == $past(fill))
    else $error("fill changed across eviction");

endmodule
